>>> design/numeric_literal_classifier_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the numeric literal classifier
// Shorthand for clocked implications, reset-qualified on arst_n.
// ----------------------------------------------------------------------------
`ifndef NUMERIC_LITERAL_CLASSIFIER_TOP_ASSERT_SVH
`define NUMERIC_LITERAL_CLASSIFIER_TOP_ASSERT_SVH

// Same-cycle implication: when a holds, b holds.
`define NLC_ASSERT_IMPL(label, a, b, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) \
		else $error(msg);

// Next-cycle implication: when a holds, b holds in the following cycle.
`define NLC_ASSERT_NEXT(label, a, b, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) \
		else $error(msg);

`endif

>>> design/nlc_pkg.sv
// ----------------------------------------------------------------------------
// nlc_pkg
// Types, character codes, token kinds and scanner transition functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nlc_pkg;

	localparam int CHAR_W = 8;
	localparam int KIND_W = 3;

	typedef logic [CHAR_W-1:0] char_t;
	typedef logic [KIND_W-1:0] kind_t;

	localparam kind_t KIND_DEC   = 3'd0;
	localparam kind_t KIND_OCT   = 3'd1;
	localparam kind_t KIND_HEX   = 3'd2;
	localparam kind_t KIND_FLOAT = 3'd3;
	localparam kind_t KIND_MAL   = 3'd4;

	localparam char_t CH_ZERO  = 8'h30;
	localparam char_t CH_SEVEN = 8'h37;
	localparam char_t CH_NINE  = 8'h39;
	localparam char_t CH_DOT   = 8'h2E;
	localparam char_t CH_LC_X  = 8'h78;
	localparam char_t CH_UC_X  = 8'h58;
	localparam char_t CH_LC_E  = 8'h65;
	localparam char_t CH_UC_E  = 8'h45;
	localparam char_t CH_LC_A  = 8'h61;
	localparam char_t CH_LC_F  = 8'h66;
	localparam char_t CH_UC_A  = 8'h41;
	localparam char_t CH_UC_F  = 8'h46;
	localparam char_t CH_PLUS  = 8'h2B;
	localparam char_t CH_MINUS = 8'h2D;
	localparam char_t CH_SPACE = 8'h20;
	localparam char_t CH_TAB   = 8'h09;
	localparam char_t CH_CR    = 8'h0D;

	typedef enum logic [11:0] {
		PH_IDLE  = 12'b0000_0000_0001,
		PH_ZERO  = 12'b0000_0000_0010,
		PH_DEC   = 12'b0000_0000_0100,
		PH_OCT   = 12'b0000_0000_1000,
		PH_HEXX  = 12'b0000_0001_0000,
		PH_HEX   = 12'b0000_0010_0000,
		PH_DOT   = 12'b0000_0100_0000,
		PH_FRAC  = 12'b0000_1000_0000,
		PH_EXP   = 12'b0001_0000_0000,
		PH_ESIGN = 12'b0010_0000_0000,
		PH_EXPD  = 12'b0100_0000_0000,
		PH_BAD   = 12'b1000_0000_0000
	} phase_t;

	function automatic logic is_blank(input char_t c);
		return (c inside {CH_SPACE, [CH_TAB:CH_CR]});
	endfunction

	function automatic logic is_digit(input char_t c);
		return (c inside {[CH_ZERO:CH_NINE]});
	endfunction

	function automatic logic is_odigit(input char_t c);
		return (c inside {[CH_ZERO:CH_SEVEN]});
	endfunction

	function automatic logic is_hex(input char_t c);
		return (c inside {[CH_ZERO:CH_NINE], [CH_LC_A:CH_LC_F], [CH_UC_A:CH_UC_F]});
	endfunction

	// Next scanner phase for one token byte.
	function automatic phase_t advance(input phase_t ph, input char_t c);
		phase_t nxt;
		nxt = PH_BAD;
		case (ph)
			PH_IDLE: begin
				if (c == CH_ZERO) nxt = PH_ZERO;
				else if (is_digit(c)) nxt = PH_DEC;
			end
			PH_ZERO: begin
				if (c == CH_LC_X || c == CH_UC_X) nxt = PH_HEXX;
				else if (c == CH_DOT) nxt = PH_DOT;
				else if (is_odigit(c)) nxt = PH_OCT;
			end
			PH_OCT: begin
				if (c == CH_DOT) nxt = PH_DOT;
				else if (is_odigit(c)) nxt = PH_OCT;
			end
			PH_DEC: begin
				if (c == CH_DOT) nxt = PH_DOT;
				else if (is_digit(c)) nxt = PH_DEC;
			end
			PH_HEXX, PH_HEX: begin
				if (is_hex(c)) nxt = PH_HEX;
			end
			PH_DOT: begin
				if (is_digit(c)) nxt = PH_FRAC;
			end
			PH_FRAC: begin
				if (is_digit(c)) nxt = PH_FRAC;
				else if (c == CH_LC_E || c == CH_UC_E) nxt = PH_EXP;
			end
			PH_EXP: begin
				if (is_digit(c)) nxt = PH_EXPD;
				else if (c == CH_PLUS || c == CH_MINUS) nxt = PH_ESIGN;
			end
			PH_ESIGN, PH_EXPD: begin
				if (is_digit(c)) nxt = PH_EXPD;
			end
			default: begin
				nxt = PH_BAD;
			end
		endcase
		return nxt;
	endfunction

	function automatic kind_t classify(input phase_t ph);
		kind_t k;
		case (ph)
			PH_ZERO, PH_DEC:  k = KIND_DEC;
			PH_OCT:           k = KIND_OCT;
			PH_HEX:           k = KIND_HEX;
			PH_FRAC, PH_EXPD: k = KIND_FLOAT;
			default:          k = KIND_MAL;
		endcase
		return k;
	endfunction

endpackage

>>> design/numeric_literal_classifier_top.sv
// ----------------------------------------------------------------------------
// Numeric literal classifier
// A result appears on the master side in the cycle after the item that closes
// its token is accepted. One item per cycle, set by the single phase register
// updated from each byte, while no result stalls. Reset clears the scanner to
// idle between tokens and empties the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module numeric_literal_classifier_top
	import nlc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] char_in
	input  logic        s_axis_tlast,  // end_of_text
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // [7:0] lead_byte
	output logic [2:0]  m_axis_tuser,  // [2:0] token_kind
	output logic        m_axis_tlast   // final_token
);

	phase_t phase_q;
	char_t  head_q;
	logic   out_valid_q;
	char_t  lead_q;
	kind_t  kind_q;
	logic   final_q;

	logic   accept;
	logic   has_result;
	phase_t phase_n;
	char_t  head_n;
	kind_t  kind_n;
	phase_t step_phase;

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;

	always_comb begin
		head_n     = head_q;
		phase_n    = phase_q;
		has_result = 1'b0;
		kind_n     = classify(phase_q);
		step_phase = advance(phase_q, s_axis_tdata);
		if (is_blank(s_axis_tdata)) begin
			// whitespace closes an open token
			has_result = (phase_q != PH_IDLE);
			phase_n    = PH_IDLE;
		end else begin
			if (phase_q == PH_IDLE) head_n = s_axis_tdata;
			phase_n = step_phase;
			if (s_axis_tlast) begin
				has_result = 1'b1;
				kind_n     = classify(step_phase);
				phase_n    = PH_IDLE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			head_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				phase_q     <= phase_n;
				head_q      <= head_n;
				out_valid_q <= has_result;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload loads only with a fresh result
	always_ff @(posedge clk) begin
		if (accept && has_result) begin
			lead_q  <= head_n;
			kind_q  <= kind_n;
			final_q <= s_axis_tlast;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = lead_q;
	assign m_axis_tuser  = kind_q;
	assign m_axis_tlast  = final_q;

endmodule

>>> design/nlc_checker.sv
// ----------------------------------------------------------------------------
// nlc_checker
// Port-level checks for the numeric literal classifier, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "numeric_literal_classifier_top_assert.svh"

module nlc_checker
	import nlc_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       s_axis_tvalid,
	input logic       s_axis_tready,
	input logic [7:0] s_axis_tdata,
	input logic       s_axis_tlast,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata,
	input logic [2:0] m_axis_tuser,
	input logic       m_axis_tlast
);

	// A stalled result holds.
	`NLC_ASSERT_NEXT(a_hold_result, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled result changed")

	// A last byte that is not whitespace always yields a final result next cycle.
	`NLC_ASSERT_NEXT(a_last_closes, s_axis_tvalid && s_axis_tready && s_axis_tlast && !is_blank(s_axis_tdata), m_axis_tvalid && m_axis_tlast, "end of text gave no final result")

	// Input stalls only behind a stalled result.
	`NLC_ASSERT_IMPL(a_stall_cause, !s_axis_tready, m_axis_tvalid && !m_axis_tready, "input stalled without back-pressure")

	// A token never starts with whitespace and its kind is a defined code.
	`NLC_ASSERT_IMPL(a_result_sane, m_axis_tvalid, m_axis_tuser <= KIND_MAL && m_axis_tdata != CH_SPACE && (m_axis_tdata < CH_TAB || m_axis_tdata > CH_CR), "bad result contents")

endmodule

bind numeric_literal_classifier_top nlc_checker u_nlc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.s_axis_tlast  (s_axis_tlast),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);
